// ===== design/rpt_pkg.sv =====
// shared types and constants of the rigid point transform
package rpt_pkg;

   // fixed field widths
   localparam int COORD_W = 32;
   localparam int ATTR_W  = 32;
   localparam int REG_W   = 32;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_DATA_W = 3 * COORD_W + ATTR_W;
   localparam int RSP_DATA_W = 3 * COORD_W + ATTR_W;

   // register stages of the rotation matrix unit
   localparam int MATRIX_STAGES = 3;
   localparam int BUSY_W = $clog2(MATRIX_STAGES + 1);

   // register indexes of the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROT_W     = 3'd0,
      REG_ROT_X     = 3'd1,
      REG_ROT_Y     = 3'd2,
      REG_ROT_Z     = 3'd3,
      REG_SHIFT_X   = 3'd4,
      REG_SHIFT_Y   = 3'd5,
      REG_SHIFT_Z   = 3'd6,
      REG_DIRECTION = 3'd7
   } csr_reg_type;

   // pose registers as one group
   typedef struct packed {
      logic [REG_W-1:0] rot_w;
      logic [REG_W-1:0] rot_x;
      logic [REG_W-1:0] rot_y;
      logic [REG_W-1:0] rot_z;
      logic [REG_W-1:0] shift_x;
      logic [REG_W-1:0] shift_y;
      logic [REG_W-1:0] shift_z;
      logic             direction;
   } pose_cfg_type;

endpackage

// ===== design/rigid_point_transform_core.sv =====
// top level of the rigid point transform: csr registers and the point pipeline
// The block takes one point per clock while req_tready is high and returns it rotated
// by the configured quaternion and shifted (inverse mode: shifted back, then rotated
// by the conjugate), with coordinates saturated and the clipped flag in rsp_tuser.
// The path has four register stages (offset subtract, nine multipliers, three-term
// sum with rounding, translation add and saturation); a stalled rsp side backs up
// the stages without losing items. The rotation matrix is derived from the csr
// registers in a separate 3-stage unit, so after reset and after every csr write
// req_tready stays low while the matrix is rebuilt.
module rigid_point_transform_core
   import rpt_pkg::*;
#(
   parameter int QUAT_FRAC_BITS = 30
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // x_in, y_in, z_in, attribute_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // x_out, y_out, z_out, attribute_out
   output logic                  rsp_tuser,   // clipped
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [REG_W-1:0]      csr_wr_data
);

   localparam int QF  = QUAT_FRAC_BITS;
   localparam int MW  = QF + 2;
   localparam int DW  = COORD_W + 1;
   localparam int MPW = MW + DW;
   localparam int SW  = MPW + 2;
   localparam int RW  = SW - QF;
   localparam int OW  = RW + 1;
   localparam logic signed [SW-1:0] S_HALF = SW'(128'd1 << (QF - 1));
   localparam logic signed [OW-1:0] O_MAX =
      {{(OW-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
   localparam logic signed [OW-1:0] O_MIN =
      {{(OW-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

   pose_cfg_type           cfg_ff, cfg_in;
   logic [BUSY_W-1:0]      busy_ff, busy_in;
   logic [8:0][MW-1:0]     matrix;
   logic [REG_W-1:0]       sub_off [3];
   logic [REG_W-1:0]       add_off [3];

   logic                   v1_ff, v2_ff, v3_ff, v4_ff;
   logic                   rdy1, rdy2, rdy3, rdy4;
   logic signed [DW-1:0]   d_in [3];
   logic signed [DW-1:0]   d_ff [3];
   logic signed [MPW-1:0]  p_in [9];
   logic signed [MPW-1:0]  p_ff [9];
   logic signed [SW-1:0]   s_sum [3];
   logic signed [RW-1:0]   r_in [3];
   logic signed [RW-1:0]   r_ff [3];
   logic signed [OW-1:0]   o_sum [3];
   logic [COORD_W-1:0]     o_in [3];
   logic [COORD_W-1:0]     o_ff [3];
   logic                   clip_in, clip_ff;
   logic [ATTR_W-1:0]      a1_ff, a2_ff, a3_ff, a4_ff;

   // csr register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_reg_type'(csr_index))
            REG_ROT_W:     cfg_in.rot_w     = csr_wr_data;
            REG_ROT_X:     cfg_in.rot_x     = csr_wr_data;
            REG_ROT_Y:     cfg_in.rot_y     = csr_wr_data;
            REG_ROT_Z:     cfg_in.rot_z     = csr_wr_data;
            REG_SHIFT_X:   cfg_in.shift_x   = csr_wr_data;
            REG_SHIFT_Y:   cfg_in.shift_y   = csr_wr_data;
            REG_SHIFT_Z:   cfg_in.shift_z   = csr_wr_data;
            REG_DIRECTION: cfg_in.direction = csr_wr_data[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // hold off items while the matrix settles
   always_comb begin
      if (csr_wr_en) begin
         busy_in = BUSY_W'(MATRIX_STAGES);
      end else if (busy_ff != '0) begin
         busy_in = busy_ff - 1'b1;
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot_w     <= REG_W'(64'd1 << QF);
         cfg_ff.rot_x     <= '0;
         cfg_ff.rot_y     <= '0;
         cfg_ff.rot_z     <= '0;
         cfg_ff.shift_x   <= '0;
         cfg_ff.shift_y   <= '0;
         cfg_ff.shift_z   <= '0;
         cfg_ff.direction <= 1'b0;
         busy_ff          <= BUSY_W'(MATRIX_STAGES);
      end else begin
         cfg_ff  <= cfg_in;
         busy_ff <= busy_in;
      end
   end

   rpt_matrix #(
      .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
   ) u_matrix (
      .clock     (clock),
      .cfg       (cfg_ff),
      .matrix_ff (matrix)
   );

   // translation is subtracted first in inverse mode, added last in forward mode
   always_comb begin
      sub_off[0] = cfg_ff.direction ? cfg_ff.shift_x : '0;
      sub_off[1] = cfg_ff.direction ? cfg_ff.shift_y : '0;
      sub_off[2] = cfg_ff.direction ? cfg_ff.shift_z : '0;
      add_off[0] = cfg_ff.direction ? '0 : cfg_ff.shift_x;
      add_off[1] = cfg_ff.direction ? '0 : cfg_ff.shift_y;
      add_off[2] = cfg_ff.direction ? '0 : cfg_ff.shift_z;
   end

   // stage handshake
   assign rdy4 = !v4_ff || rsp_tready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_tready = rdy1 && (busy_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid && req_tready;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // stage 1: offset subtract at full width
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d_in[k] = DW'($signed(req_tdata[k*COORD_W +: COORD_W]))
                 - DW'($signed(sub_off[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         d_ff  <= d_in;
         a1_ff <= req_tdata[3*COORD_W +: ATTR_W];
      end
   end

   // stage 2: nine products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            p_in[i*3+j] = MPW'($signed(matrix[i*3+j])) * MPW'(d_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         p_ff  <= p_in;
         a2_ff <= a1_ff;
      end
   end

   // stage 3: exact row sums, round half up to the coordinate format
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s_sum[i] = SW'(p_ff[i*3]) + SW'(p_ff[i*3+1]) + SW'(p_ff[i*3+2]) + S_HALF;
         r_in[i]  = s_sum[i][SW-1:QF];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         r_ff  <= r_in;
         a3_ff <= a2_ff;
      end
   end

   // stage 4: translation add and saturation
   always_comb begin
      clip_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         o_sum[k] = OW'(r_ff[k]) + OW'($signed(add_off[k]));
         if (o_sum[k] > O_MAX) begin
            o_in[k] = O_MAX[COORD_W-1:0];
            clip_in = 1'b1;
         end else if (o_sum[k] < O_MIN) begin
            o_in[k] = O_MIN[COORD_W-1:0];
            clip_in = 1'b1;
         end else begin
            o_in[k] = o_sum[k][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         o_ff    <= o_in;
         clip_ff <= clip_in;
         a4_ff   <= a3_ff;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {a4_ff, o_ff[2], o_ff[1], o_ff[0]};
   assign rsp_tuser  = clip_ff;

endmodule

// ===== design/rpt_matrix.sv =====
// rotation matrix unit: quaternion registers to rounded matrix, transposed in inverse mode
module rpt_matrix
   import rpt_pkg::*;
#(
   parameter int QUAT_FRAC_BITS = 30
) (
   input  logic                                clock,
   input  pose_cfg_type                        cfg,
   output logic [8:0][QUAT_FRAC_BITS+1:0]      matrix_ff
);

   localparam int QF = QUAT_FRAC_BITS;
   localparam int QW = QF + 2;
   localparam int FW = 2 * QW;
   localparam logic signed [REG_W-1:0] Q_ONE  = REG_W'(64'd1 << QF);
   localparam logic signed [REG_W-1:0] Q_MONE = -Q_ONE;
   localparam logic signed [FW-1:0] F_ONE2 = FW'(128'd1 << (2 * QF));
   localparam logic signed [FW-1:0] F_HALF = FW'(128'd1 << (QF - 1));
   localparam logic signed [FW-1:0] R_ONE  = FW'(128'd1 << QF);
   localparam logic signed [FW-1:0] R_MONE = -R_ONE;

   logic signed [REG_W-1:0] raw [4];
   logic signed [QW-1:0]    q_in [4];
   logic signed [QW-1:0]    q_ff [4];
   logic signed [FW-1:0]    p_in [9];
   logic signed [FW-1:0]    p_ff [9];
   logic signed [FW-1:0]    full [9];
   logic signed [FW-1:0]    rnd  [9];
   logic [8:0][QW-1:0]      elem;
   logic [8:0][QW-1:0]      matrix_in;

   // clamp the components to plus or minus one
   always_comb begin
      raw[0] = $signed(cfg.rot_w);
      raw[1] = $signed(cfg.rot_x);
      raw[2] = $signed(cfg.rot_y);
      raw[3] = $signed(cfg.rot_z);
      for (int k = 0; k < 4; k++) begin
         if (raw[k] > Q_ONE) begin
            q_in[k] = Q_ONE[QW-1:0];
         end else if (raw[k] < Q_MONE) begin
            q_in[k] = Q_MONE[QW-1:0];
         end else begin
            q_in[k] = raw[k][QW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   // component products: xx yy zz xy xz yz wx wy wz
   always_comb begin
      p_in[0] = q_ff[1] * q_ff[1];
      p_in[1] = q_ff[2] * q_ff[2];
      p_in[2] = q_ff[3] * q_ff[3];
      p_in[3] = q_ff[1] * q_ff[2];
      p_in[4] = q_ff[1] * q_ff[3];
      p_in[5] = q_ff[2] * q_ff[3];
      p_in[6] = q_ff[0] * q_ff[1];
      p_in[7] = q_ff[0] * q_ff[2];
      p_in[8] = q_ff[0] * q_ff[3];
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   // exact elements, round half up, clamp, transpose for inverse mode
   always_comb begin
      full[0] = F_ONE2 - ((p_ff[1] + p_ff[2]) <<< 1);
      full[1] = (p_ff[3] - p_ff[8]) <<< 1;
      full[2] = (p_ff[4] + p_ff[7]) <<< 1;
      full[3] = (p_ff[3] + p_ff[8]) <<< 1;
      full[4] = F_ONE2 - ((p_ff[0] + p_ff[2]) <<< 1);
      full[5] = (p_ff[5] - p_ff[6]) <<< 1;
      full[6] = (p_ff[4] - p_ff[7]) <<< 1;
      full[7] = (p_ff[5] + p_ff[6]) <<< 1;
      full[8] = F_ONE2 - ((p_ff[0] + p_ff[1]) <<< 1);
      for (int k = 0; k < 9; k++) begin
         rnd[k] = (full[k] + F_HALF) >>> QF;
         if (rnd[k] > R_ONE) begin
            elem[k] = R_ONE[QW-1:0];
         end else if (rnd[k] < R_MONE) begin
            elem[k] = R_MONE[QW-1:0];
         end else begin
            elem[k] = rnd[k][QW-1:0];
         end
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            matrix_in[i*3+j] = cfg.direction ? elem[j*3+i] : elem[i*3+j];
         end
      end
   end

   always_ff @(posedge clock) begin
      matrix_ff <= matrix_in;
   end

endmodule

// ===== design/rpt_checker.sv =====
// port checker of the rigid point transform and its bind
module rpt_port_checks
   import rpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  csr_wr_en
);

   // reset empties the pipeline and holds off items while the matrix settles
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("pipeline not quiet after reset");

   // a csr write blocks input until the matrix is rebuilt
   a_csr_holdoff: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !req_tready)
      else $error("item accepted while matrix recomputes");

   // an accepted item reaches the output when the output side keeps draining
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
      |=> rsp_tvalid)
      else $error("item lost in the pipeline");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
      && $stable(rsp_tuser))
      else $error("stalled item changed");

endmodule

bind rigid_point_transform_core rpt_port_checks u_rpt_port_checks (.*);

// ===== dv/rpt_checker.sv =====
// checker for the rigid point transform: tracks the pose, predicts each point, compares
`timescale 1ns / 100ps
module rpt_checker
   import rpt_pkg::*;
#(
   parameter int QUAT_FRAC_BITS = 30
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // x_in, y_in, z_in, attribute_in
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // x_out, y_out, z_out, attribute_out
   input  logic                  rsp_tuser,   // clipped
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [REG_W-1:0]      csr_wr_data,
   output int                    error_count,
   output int                    results_due
);

   typedef logic signed [95:0] wide_type;

   localparam longint   UNIT      = longint'(1) << QUAT_FRAC_BITS;
   localparam longint   UNIT_SQ   = longint'(1) << (2 * QUAT_FRAC_BITS);
   localparam wide_type HALF_LSB  = wide_type'(1) <<< (QUAT_FRAC_BITS - 1);
   localparam wide_type COORD_MAX = 96'sd2147483647;
   localparam wide_type COORD_MIN = -96'sd2147483648;

   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [ATTR_W-1:0]  attr;
      logic               clipped;
   } point_out_type;

   pose_cfg_type  pose;
   point_out_type transformed_q[$];

   // limit a quaternion component or matrix element to [-1.0, +1.0]
   function automatic longint clamp_unit(input longint v);
      return (v < -UNIT) ? -UNIT : ((v > UNIT) ? UNIT : v);
   endfunction

   // rotate and shift one point under the given pose
   function automatic point_out_type transform_point(input pose_cfg_type cfg,
                                                     input logic [REQ_DATA_W-1:0] word);
      longint        qw, qx, qy, qz;
      longint        full [9];
      longint        mat [9];
      wide_type      pt [3];
      wide_type      ofs [3];
      wide_type      acc;
      wide_type      coord;
      point_out_type res;
      logic [COORD_W-1:0] sat [3];
      int            i, j;
      qw = clamp_unit(longint'(signed'(cfg.rot_w)));
      qx = clamp_unit(longint'(signed'(cfg.rot_x)));
      qy = clamp_unit(longint'(signed'(cfg.rot_y)));
      qz = clamp_unit(longint'(signed'(cfg.rot_z)));
      // rotation matrix at double precision, then rounded half up
      full[0] = UNIT_SQ - 2 * (qy * qy + qz * qz);
      full[1] = 2 * (qx * qy - qw * qz);
      full[2] = 2 * (qx * qz + qw * qy);
      full[3] = 2 * (qx * qy + qw * qz);
      full[4] = UNIT_SQ - 2 * (qx * qx + qz * qz);
      full[5] = 2 * (qy * qz - qw * qx);
      full[6] = 2 * (qx * qz - qw * qy);
      full[7] = 2 * (qy * qz + qw * qx);
      full[8] = UNIT_SQ - 2 * (qx * qx + qy * qy);
      for (i = 0; i < 9; i++)
         mat[i] = clamp_unit((full[i] + (UNIT >>> 1)) >>> QUAT_FRAC_BITS);
      pt[0]  = wide_type'(signed'(word[0 +: COORD_W]));
      pt[1]  = wide_type'(signed'(word[COORD_W +: COORD_W]));
      pt[2]  = wide_type'(signed'(word[2 * COORD_W +: COORD_W]));
      ofs[0] = wide_type'(signed'(cfg.shift_x));
      ofs[1] = wide_type'(signed'(cfg.shift_y));
      ofs[2] = wide_type'(signed'(cfg.shift_z));
      res.clipped = 1'b0;
      for (i = 0; i < 3; i++) begin
         acc = '0;
         // inverse: offset subtracted at full width, transposed matrix
         if (cfg.direction) begin
            for (j = 0; j < 3; j++)
               acc += wide_type'(mat[j * 3 + i]) * (pt[j] - ofs[j]);
            coord = (acc + HALF_LSB) >>> QUAT_FRAC_BITS;
         end else begin
            for (j = 0; j < 3; j++)
               acc += wide_type'(mat[i * 3 + j]) * pt[j];
            coord = ((acc + HALF_LSB) >>> QUAT_FRAC_BITS) + ofs[i];
         end
         // saturate to the coordinate range
         if (coord > COORD_MAX) begin
            sat[i] = 32'h7FFF_FFFF;
            res.clipped = 1'b1;
         end else if (coord < COORD_MIN) begin
            sat[i] = 32'h8000_0000;
            res.clipped = 1'b1;
         end else begin
            sat[i] = coord[COORD_W-1:0];
         end
      end
      res.x    = sat[0];
      res.y    = sat[1];
      res.z    = sat[2];
      res.attr = word[3 * COORD_W +: ATTR_W];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   // watch the channels and the csr port at every rising edge
   always @(posedge clock) begin
      point_out_type want;
      if (reset) begin
         pose = '0;
         pose.rot_w = 32'(UNIT);
         transformed_q.delete();
      end else begin
         // compare a returned item with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (transformed_q.size() == 0) begin
               report_mismatch("item with nothing pending", rsp_tdata[31:0], '0);
            end else begin
               want = transformed_q.pop_front();
               if (rsp_tdata[0 +: COORD_W] !== want.x)
                  report_mismatch("x_out", rsp_tdata[0 +: COORD_W], want.x);
               if (rsp_tdata[COORD_W +: COORD_W] !== want.y)
                  report_mismatch("y_out", rsp_tdata[COORD_W +: COORD_W], want.y);
               if (rsp_tdata[2 * COORD_W +: COORD_W] !== want.z)
                  report_mismatch("z_out", rsp_tdata[2 * COORD_W +: COORD_W], want.z);
               if (rsp_tdata[3 * COORD_W +: ATTR_W] !== want.attr)
                  report_mismatch("attribute_out", rsp_tdata[3 * COORD_W +: ATTR_W],
                                  want.attr);
               if (rsp_tuser !== want.clipped)
                  report_mismatch("clipped", 32'(rsp_tuser), 32'(want.clipped));
            end
         end
         // predict an accepted item under the current pose
         if (req_tvalid && req_tready)
            transformed_q = {transformed_q, transform_point(pose, req_tdata)};
         // track register writes
         if (csr_wr_en) begin
            case (csr_reg_type'(csr_index))
               REG_ROT_W:     pose.rot_w     = csr_wr_data;
               REG_ROT_X:     pose.rot_x     = csr_wr_data;
               REG_ROT_Y:     pose.rot_y     = csr_wr_data;
               REG_ROT_Z:     pose.rot_z     = csr_wr_data;
               REG_SHIFT_X:   pose.shift_x   = csr_wr_data;
               REG_SHIFT_Y:   pose.shift_y   = csr_wr_data;
               REG_SHIFT_Z:   pose.shift_z   = csr_wr_data;
               REG_DIRECTION: pose.direction = csr_wr_data[0];
               default: ;
            endcase
         end
      end
      results_due = transformed_q.size();
   end

endmodule

// ===== dv/testbench.sv =====
// top of the rigid point transform testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module testbench;
   import rpt_pkg::*;

   localparam int QUAT_FRAC        = 30;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int HOLD_CYCLES      = 200;
   localparam int SETTLE_CYCLES    = 8;
   localparam int RANDOM_PHASES    = 12;
   localparam int POINTS_PER_PHASE = 95;

   localparam logic [31:0] Q_ONE     = 32'h4000_0000;
   localparam logic [31:0] Q_NEG_ONE = 32'hC000_0000;
   localparam logic [31:0] Q45_W     = 32'd992008094;
   localparam logic [31:0] Q45_Z     = 32'd410903207;
   localparam logic [31:0] C_MAX     = 32'h7FFF_FFFF;
   localparam logic [31:0] C_MIN     = 32'h8000_0000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // x_in, y_in, z_in, attribute_in
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // x_out, y_out, z_out, attribute_out
   logic                  rsp_tuser;   // clipped
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [REG_W-1:0]      csr_wr_data;

   int error_count;
   int results_due;
   int cycle_count;
   int hold_requests;
   bit idle_on;

   rigid_point_transform_core #(.QUAT_FRAC_BITS(QUAT_FRAC)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   rpt_checker #(.QUAT_FRAC_BITS(QUAT_FRAC)) point_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .error_count (error_count),
      .results_due (results_due)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // timeout
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic pose_cfg_type make_pose(input logic [31:0] w, x, y, z, sx, sy, sz,
                                              input logic dir);
      pose_cfg_type p;
      p.rot_w     = w;
      p.rot_x     = x;
      p.rot_y     = y;
      p.rot_z     = z;
      p.shift_x   = sx;
      p.shift_y   = sy;
      p.shift_z   = sz;
      p.direction = dir;
      return p;
   endfunction

   // mostly values within +-256 m, one in full_one_in over the whole range
   function automatic logic [31:0] random_q16(input int full_one_in);
      if ($urandom_range(0, full_one_in - 1) == 0)
         return $urandom();
      return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
   endfunction

   // mostly a random unit quaternion, sometimes raw register words
   function automatic pose_cfg_type random_pose(input logic dir);
      real          c [4];
      real          norm;
      logic [31:0]  q [4];
      int           k;
      norm = 0.0;
      if ($urandom_range(0, 9) < 7) begin
         for (k = 0; k < 4; k++) begin
            c[k] = real'($urandom_range(0, 2000)) - 1000.0;
            norm += c[k] * c[k];
         end
         norm = $sqrt(norm);
         for (k = 0; k < 4; k++) begin
            if (norm < 1.0)
               q[k] = (k == 0) ? Q_ONE : 32'h0;
            else
               q[k] = 32'($rtoi(c[k] / norm * 1073741824.0));
         end
      end else begin
         for (k = 0; k < 4; k++)
            q[k] = $urandom();
      end
      return make_pose(q[0], q[1], q[2], q[3], random_q16(5), random_q16(5), random_q16(5),
                       dir);
   endfunction

   task automatic write_reg(input csr_reg_type idx, input logic [REG_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(negedge clock);
   endtask

   // program the whole pose, direction with junk in the unused upper bits
   task automatic write_pose(input pose_cfg_type p);
      write_reg(REG_ROT_W, p.rot_w);
      write_reg(REG_ROT_X, p.rot_x);
      write_reg(REG_ROT_Y, p.rot_y);
      write_reg(REG_ROT_Z, p.rot_z);
      write_reg(REG_SHIFT_X, p.shift_x);
      write_reg(REG_SHIFT_Y, p.shift_y);
      write_reg(REG_SHIFT_Z, p.shift_z);
      write_reg(REG_DIRECTION, {31'($urandom()), p.direction});
      csr_wr_en <= 1'b0;
   endtask

   // offer one point, after a random gap when idling is on, and wait for it to be taken
   task automatic send_point(input logic [31:0] px, py, pz, attr);
      int gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {attr, pz, py, px};
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
      @(negedge clock);
   endtask

   // stop offering until every point has come back, then let the pipe settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // result side: random stalls per item when idling is on, long hold-off on request
   initial begin
      int gap;
      int holds_done;
      holds_done = 0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_requests > holds_done) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         gap = idle_on ? $urandom_range(0, 5) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         @(negedge clock);
      end
   end

   // stimulus
   initial begin
      int phase;
      int n;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_wr_en     = 1'b0;
      csr_index     = REG_ROT_W;
      csr_wr_data   = '0;
      idle_on       = 1'b1;
      hold_requests = 0;
      reset         = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identity pose after reset: field extremes pass straight through
      send_point(32'h0, 32'h0, 32'h0, 32'h0);
      send_point(C_MAX, C_MAX, C_MAX, 32'hFFFF_FFFF);
      send_point(C_MIN, C_MIN, C_MIN, 32'h0);
      send_point(32'h0000_8000, 32'hFFFF_FFFF, 32'h0001_0000, 32'hA5A5_5A5A);

      // extreme translation, forward: overflow both ways
      wait_idle();
      write_pose(make_pose(Q_ONE, 0, 0, 0, C_MAX, C_MIN, C_MAX, 1'b0));
      send_point(C_MAX, C_MIN, 32'hFFFF_FFFF, 32'h1234_5678);
      send_point(C_MIN, C_MAX, 32'h0, 32'h8765_4321);

      // same translation, inverse: full-width differences
      wait_idle();
      write_pose(make_pose(Q_ONE, 0, 0, 0, C_MAX, C_MIN, C_MAX, 1'b1));
      send_point(C_MIN, C_MAX, C_MIN, 32'h0F0F_0F0F);
      send_point(32'h0, 32'h0, 32'h0, 32'hF0F0_F0F0);

      // half turn about z: negating the most negative coordinate saturates
      wait_idle();
      write_pose(make_pose(32'h0, 32'h0, 32'h0, Q_ONE, 0, 0, 0, 1'b0));
      send_point(C_MIN, C_MIN, C_MIN, 32'h0000_0001);
      send_point(32'h0001_8000, 32'hFFFE_8000, 32'h0000_0001, 32'h8000_0000);

      // 45 degrees about z, inverse: huge differences that cancel in one axis
      wait_idle();
      write_pose(make_pose(Q45_W, 32'h0, 32'h0, Q45_Z, C_MAX, C_MAX, 32'h0, 1'b1));
      send_point(C_MIN, C_MIN, 32'd5, 32'hDEAD_BEEF);
      send_point(32'h1234_5678, 32'hF012_3457, C_MAX, 32'h7FFF_FFFF);

      // components beyond one and a non-unit quaternion: clamped
      wait_idle();
      write_pose(make_pose(C_MAX, C_MIN, Q_NEG_ONE, Q_ONE, 0, 0, 0, 1'b0));
      send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h5555_AAAA);
      send_point(C_MAX, C_MIN, 32'h4000_0000, 32'hAAAA_5555);

      // random poses and points, some phases without idling
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         write_pose(random_pose(phase[0]));
         idle_on = (phase % 3 != 2);
         for (n = 0; n < POINTS_PER_PHASE; n++) begin
            if (n == 20 && phase % 5 == 1)
               hold_requests++;
            send_point(random_q16(8), random_q16(8), random_q16(8), $urandom());
         end
      end

      wait_idle();
      if (error_count == 0 && results_due == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/rpt_pkg.sv
design/rpt_matrix.sv
design/rigid_point_transform_core.sv
design/rpt_checker.sv
dv/rpt_checker.sv
dv/testbench.sv
